// ----- hdl/wbps_pkg.sv -----
`timescale 1ns / 1ps

package wbps_pkg;

	// Operation codes carried by an input word.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SCAN    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	localparam int unsigned LEN_W    = 9;
	localparam int unsigned OFFSET_W = 32;

	// One input word.
	typedef struct packed {
		op_t        op;
		logic [7:0] entry_index;
		logic [7:0] pattern_byte;
		logic       wildcard_req;
		logic [7:0] image_byte;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic                match_now;
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} out_word_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic       load;
		logic       scan;
		logic       clear;
		logic [7:0] entry_index;
		logic [7:0] pattern_byte;
		logic       wildcard_req;
		logic [7:0] image_byte;
	} cell_ctl_t;

	// Scan word waiting for its result to be resolved.
	typedef struct packed {
		logic                valid;
		logic [OFFSET_W-1:0] pos;
	} scan_tok_t;

endpackage

// ----- hdl/wbps_cell.sv -----
`timescale 1ns / 1ps

module wbps_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::cell_ctl_t ctl,
	input  logic                prev_match,
	output logic                match
);

	logic [7:0] byte_q;
	logic       wild_q;
	logic       match_q;
	logic       hit;

	// Pattern entry storage, written when the load index selects this cell.
	always_ff @(posedge clk) begin
		if (ctl.load && (32'(ctl.entry_index) == CELL_IDX)) begin
			byte_q <= ctl.pattern_byte;
			wild_q <= ctl.wildcard_req;
		end
	end

	assign hit = wild_q | (byte_q == ctl.image_byte);

	// Partial match bit: the neighbor's bit shifts in, gated by this entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.scan) begin
			match_q <= prev_match & hit;
		end
	end

	assign match = match_q;

endmodule

// ----- hdl/wbps_result.sv -----
`timescale 1ns / 1ps

module wbps_result #(
	parameter int unsigned MAX_PATTERN = 256,
	parameter int unsigned IDX_W       = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [MAX_PATTERN-1:0] match_vec,
	input  logic [IDX_W-1:0]      sel_idx,
	input  wbps_pkg::scan_tok_t   tok,
	input  logic                  clear,
	input  logic                  out_stall,
	output logic                  out_free,
	output logic                  out_valid,
	output wbps_pkg::out_word_t   out_word
);

	logic                          out_valid_q;
	wbps_pkg::out_word_t           out_word_q;
	logic                          found_q;
	logic [wbps_pkg::OFFSET_W-1:0] offset_q;
	logic                          hit;
	logic                          take;
	logic [wbps_pkg::OFFSET_W-1:0] start_pos;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign take      = tok.valid & out_free;
	assign hit       = match_vec[sel_idx] & ~found_q;
	assign start_pos = tok.pos - wbps_pkg::OFFSET_W'(sel_idx);

	// Sticky found flag and latched start offset; a restart clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			offset_q <= '0;
		end else if (clear) begin
			found_q  <= 1'b0;
			offset_q <= '0;
		end else if (take && hit) begin
			found_q  <= 1'b1;
			offset_q <= start_pos;
		end
	end

	// Output register holds a word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_word_q.match_now    <= hit;
			out_word_q.found        <= found_q | hit;
			out_word_q.match_offset <= hit ? start_pos : offset_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ----- hdl/wildcard_byte_pattern_scanner_top.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// cfg      in         cfg_wr_en          cfg_wr_data: pattern_length
// in       in         in_valid/in_stall  in_word: op, entry, byte, wildcard, image byte
// out      out        out_valid/out_stall out_word: match_now, found, match_offset
//
// One word is accepted per cycle unless in_stall is high; scan results are registered.
// The chain of cells updates the whole match vector in the cycle a scan word is accepted;
// the result stage picks the bit at the pattern length and updates the found state.
// Reset clears the match vector, position, found state and sets the length to 1;
// pattern entries are not cleared and must be loaded before scanning.
// A stalled output holds its word; input stalls only while a scan word waits behind it.

module wildcard_byte_pattern_scanner_top #(
	parameter int unsigned MAX_PATTERN = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [wbps_pkg::LEN_W-1:0]       cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  wbps_pkg::in_word_t               in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output wbps_pkg::out_word_t              out_word
);

	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [10:0] MAX_L = 11'(MAX_PATTERN);

	logic [wbps_pkg::LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]              sel_idx;
	logic                          in_fire;
	wbps_pkg::cell_ctl_t           ctl;
	logic [wbps_pkg::OFFSET_W-1:0] pos_q;
	logic                          scan_valid_s1;
	logic [wbps_pkg::OFFSET_W-1:0] scan_pos_s1;
	wbps_pkg::scan_tok_t           tok;
	logic                          out_free;
	logic [MAX_PATTERN-1:0]        match_vec;
	logic [MAX_PATTERN:0]          chain;

	// Pattern length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= wbps_pkg::LEN_W'(1);
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// Index of the last pattern entry in use, with the length clamped to 1..MAX_PATTERN.
	always_comb begin
		if (len_q == '0) begin
			sel_idx = '0;
		end else if (11'(len_q) > MAX_L) begin
			sel_idx = IDX_W'(MAX_L - 11'd1);
		end else begin
			sel_idx = IDX_W'(len_q - wbps_pkg::LEN_W'(1));
		end
	end

	// Input handshake and operation decode.
	assign in_stall = scan_valid_s1 & ~out_free;
	assign in_fire  = in_valid & ~in_stall;

	always_comb begin
		ctl              = '0;
		ctl.entry_index  = in_word.entry_index;
		ctl.pattern_byte = in_word.pattern_byte;
		ctl.wildcard_req = in_word.wildcard_req;
		ctl.image_byte   = in_word.image_byte;
		unique case (in_word.op)
			wbps_pkg::OP_LOAD:    ctl.load  = in_fire;
			wbps_pkg::OP_SCAN:    ctl.scan  = in_fire;
			wbps_pkg::OP_RESTART: ctl.clear = in_fire;
			default:              ctl       = ctl;
		endcase
	end

	// Scan position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.clear) begin
			pos_q <= '0;
		end else if (ctl.scan) begin
			pos_q <= pos_q + wbps_pkg::OFFSET_W'(1);
		end
	end

	// Scan word waiting for the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_valid_s1 <= 1'b0;
		end else if (ctl.scan) begin
			scan_valid_s1 <= 1'b1;
		end else if (out_free) begin
			scan_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			scan_pos_s1 <= pos_q;
		end
	end

	assign tok.valid = scan_valid_s1;
	assign tok.pos   = scan_pos_s1;

	// Chain of cells; the first cell always sees a match ahead of it.
	assign chain[0] = 1'b1;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		wbps_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_match(chain[k]),
			.match     (chain[k+1])
		);
		assign match_vec[k] = chain[k+1];
	end

	wbps_result #(
		.MAX_PATTERN(MAX_PATTERN),
		.IDX_W      (IDX_W)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.match_vec(match_vec),
		.sel_idx  (sel_idx),
		.tok      (tok),
		.clear    (ctl.clear),
		.out_stall(out_stall),
		.out_free (out_free),
		.out_valid(out_valid),
		.out_word (out_word)
	);

endmodule
